// ----- sv/cpa_pkg.sv -----
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared constants, types and helpers for the covariance outer-product
// accumulator: sizes, function codes, controller states and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MAX_ATOMS = 64;
  localparam int COORD_W   = 20;
  localparam int DISP_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DISP_W;
  localparam int ACC_W     = 64;
  localparam int TALLY_W   = 32;
  localparam int CNT_W     = 7;
  localparam int FUNC_W    = 2;
  localparam int SEL_W     = 8;
  localparam int SLOT_W    = $clog2(MAX_ATOMS);
  localparam int AXIS_W    = 2;
  localparam int VEC_LEN   = 3 * MAX_ATOMS;
  localparam int IDX_W     = $clog2(VEC_LEN);
  localparam int ACC_DEPTH = VEC_LEN * VEC_LEN;
  localparam int ACC_AW    = $clog2(ACC_DEPTH);
  localparam int REF_W     = 3 * COORD_W;
  localparam int ROW_W     = 3 * DISP_W;

  localparam logic [CNT_W-1:0]  ATOM_CNT_RESET = CNT_W'(MAX_ATOMS);
  localparam logic [AXIS_W-1:0] AXIS_LAST      = AXIS_W'(2);
  localparam logic [ACC_AW-1:0] ACC_LAST_ADDR  = ACC_AW'(ACC_DEPTH - 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Function codes of an input item
  localparam logic [FUNC_W-1:0] FUNC_LOAD_REF = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_READ     = FUNC_W'(2);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_REF,
    ST_SAMPLE_RD,
    ST_SAMPLE_WR,
    ST_FETCH,
    ST_ROW,
    ST_DRAIN,
    ST_READ_RD,
    ST_READ_OUT
  } cpa_state_t;

  typedef struct packed {
    logic              latch;       // capture the input item
    logic              ref_we;      // write reference row
    logic              disp_we;     // write displacement row
    logic [SLOT_W-1:0] disp_ra;     // displacement read row
    logic              load_di;     // capture row element of vector index i
    logic              acc_issue;   // start one multiply-accumulate
    logic [SLOT_W-1:0] ia;
    logic [AXIS_W-1:0] ik;
    logic [SLOT_W-1:0] ja;
    logic [AXIS_W-1:0] jk;
    logic              clear_we;    // clearing pass write
    logic [ACC_AW-1:0] clear_addr;
    logic              out_load;    // capture a result
    logic              frame_done;  // count one frame
  } cpa_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] last_atom;   // effective atom count minus one
    logic              pipe_busy;   // multiply-accumulate stages in flight
  } cpa_stat_t;

  // Vector index of atom a, axis k
  function automatic logic [IDX_W-1:0] lin_idx(input logic [SLOT_W-1:0] atom,
                                               input logic [AXIS_W-1:0] axis);
    return IDX_W'(atom) * IDX_W'(3) + IDX_W'(axis);
  endfunction

  // Flat accumulator address of entry (row, col)
  function automatic logic [ACC_AW-1:0] acc_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    return ACC_AW'(row) * ACC_AW'(VEC_LEN) + ACC_AW'(col);
  endfunction

endpackage

// ----- sv/cpa_ram.sv -----
// ----------------------------------------------------------------------------
// cpa_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/cpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpa_ctrl
// Controller: clearing pass, item dispatch and the row/column sequencer
// that walks the outer product of one frame.
// ----------------------------------------------------------------------------
module cpa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cpa_pkg::FUNC_W-1:0]  in_func,
  input  logic                        in_frame_end,
  input  cpa_pkg::cpa_stat_t          stat,
  output cpa_pkg::cpa_cmd_t           cmd,
  output logic                        busy
);
  import cpa_pkg::*;

  cpa_state_t        state_r, state_nxt;
  logic [ACC_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0] ia_r, ia_nxt, ja_r, ja_nxt;
  logic [AXIS_W-1:0] ik_r, ik_nxt, jk_r, jk_nxt;
  logic              fend_r, fend_nxt;
  logic              accept;
  logic              j_last, i_last;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign j_last = (ja_r == stat.last_atom) && (jk_r == AXIS_LAST);
  assign i_last = (ia_r == stat.last_atom) && (ik_r == AXIS_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      ia_r       <= '0;
      ik_r       <= '0;
      ja_r       <= '0;
      jk_r       <= '0;
      fend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      ia_r       <= ia_nxt;
      ik_r       <= ik_nxt;
      ja_r       <= ja_nxt;
      jk_r       <= jk_nxt;
      fend_r     <= fend_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    ia_nxt       = ia_r;
    ik_nxt       = ik_r;
    ja_nxt       = ja_r;
    jk_nxt       = jk_r;
    fend_nxt     = fend_r;
    cmd          = '0;
    cmd.ia       = ia_r;
    cmd.ik       = ik_r;
    cmd.ja       = ja_r;
    cmd.jk       = jk_r;
    cmd.clear_addr = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ACC_LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          fend_nxt  = in_frame_end;
          unique case (in_func)
            FUNC_LOAD_REF: state_nxt = ST_LOAD_REF;
            FUNC_SAMPLE:   state_nxt = ST_SAMPLE_RD;
            FUNC_READ:     state_nxt = ST_READ_RD;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_REF: begin
        cmd.ref_we = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SAMPLE_RD: begin
        state_nxt = ST_SAMPLE_WR;
      end
      ST_SAMPLE_WR: begin
        cmd.disp_we = 1'b1;
        ia_nxt = '0;
        ik_nxt = '0;
        ja_nxt = '0;
        jk_nxt = '0;
        state_nxt = fend_r ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        cmd.disp_ra = ia_r;
        state_nxt   = ST_ROW;
      end
      ST_ROW: begin
        cmd.disp_ra   = ja_r;
        cmd.acc_issue = 1'b1;
        cmd.load_di   = (ja_r == '0) && (jk_r == '0);
        if (j_last) begin
          ja_nxt = '0;
          jk_nxt = '0;
          if (i_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_FETCH;
            if (ik_r == AXIS_LAST) begin
              ik_nxt = '0;
              ia_nxt = ia_r + 1'b1;
            end else begin
              ik_nxt = ik_r + 1'b1;
            end
          end
        end else if (jk_r == AXIS_LAST) begin
          jk_nxt = '0;
          ja_nxt = ja_r + 1'b1;
        end else begin
          jk_nxt = jk_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.frame_done = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_READ_RD: begin
        state_nxt = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/cpa_dp.sv -----
// ----------------------------------------------------------------------------
// cpa_dp
// Datapath: item registers, reference, displacement and accumulator memories,
// the two-stage multiply / saturating-add pipeline, frame tally and results.
// ----------------------------------------------------------------------------
module cpa_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cpa_pkg::cpa_cmd_t                  cmd,
  output cpa_pkg::cpa_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [cpa_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic [cpa_pkg::SLOT_W-1:0]         in_atom_slot,
  input  logic signed [cpa_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [cpa_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [cpa_pkg::COORD_W-1:0] in_coord_z,
  input  logic [cpa_pkg::SEL_W-1:0]          in_row_sel,
  input  logic [cpa_pkg::SEL_W-1:0]          in_col_sel,
  output logic                               out_valid,
  output logic signed [cpa_pkg::ACC_W-1:0]   out_entry_sum,
  output logic [cpa_pkg::TALLY_W-1:0]        out_frames_seen,
  output logic                               out_overflowed
);
  import cpa_pkg::*;

  // Item registers
  logic [SLOT_W-1:0]         slot_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [SEL_W-1:0]          row_r, col_r;

  logic [CNT_W-1:0]          atom_cnt_r;
  logic [TALLY_W-1:0]        frames_r;
  logic                      sat_seen_r;

  // Memory ports
  logic [REF_W-1:0]  ref_rdata;
  logic [ROW_W-1:0]  disp_wdata, disp_rdata;
  logic              acc_we;
  logic [ACC_AW-1:0] acc_waddr, acc_raddr, issue_addr, read_addr;
  logic [ACC_W-1:0]  acc_wdata, acc_rdata;

  // Pipeline
  logic signed [DISP_W-1:0] di_r, dj;
  logic                     mul_v_r, wr_v_r;
  logic [AXIS_W-1:0]        jk_d_r;
  logic [ACC_AW-1:0]        addr_d1_r, addr_d2_r;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [ACC_W-1:0]  acc_r, sat_val;
  logic signed [ACC_W:0]    sum;
  logic                     ovf;

  logic signed [DISP_W-1:0] dx, dy, dz;
  logic                     rd_in_range;

  function automatic logic signed [DISP_W-1:0] pick(input logic [ROW_W-1:0] row,
                                                    input logic [AXIS_W-1:0] k);
    logic signed [DISP_W-1:0] v;
    unique case (k)
      AXIS_W'(0): v = row[DISP_W-1:0];
      AXIS_W'(1): v = row[2*DISP_W-1:DISP_W];
      default:    v = row[3*DISP_W-1:2*DISP_W];
    endcase
    return v;
  endfunction

  // Effective atom count: zero acts as one, above the maximum saturates
  always_comb begin
    stat.pipe_busy = mul_v_r || wr_v_r;
    if (atom_cnt_r == '0) begin
      stat.last_atom = '0;
    end else if (atom_cnt_r > CNT_W'(MAX_ATOMS)) begin
      stat.last_atom = SLOT_W'(MAX_ATOMS - 1);
    end else begin
      stat.last_atom = SLOT_W'(atom_cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_cnt_r <= ATOM_CNT_RESET;
      frames_r   <= '0;
      sat_seen_r <= 1'b0;
      mul_v_r    <= 1'b0;
      wr_v_r     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        atom_cnt_r <= cfg_wdata;
      end
      if (cmd.frame_done && (frames_r != '1)) begin
        frames_r <= frames_r + 1'b1;
      end
      if (wr_v_r && ovf) begin
        sat_seen_r <= 1'b1;
      end
      mul_v_r   <= cmd.acc_issue;
      wr_v_r    <= mul_v_r;
      out_valid <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      slot_r <= in_atom_slot;
      cx_r   <= in_coord_x;
      cy_r   <= in_coord_y;
      cz_r   <= in_coord_z;
      row_r  <= in_row_sel;
      col_r  <= in_col_sel;
    end
    if (cmd.load_di) begin
      di_r <= pick(disp_rdata, cmd.ik);
    end
    jk_d_r    <= cmd.jk;
    addr_d1_r <= issue_addr;
    prod_r    <= prod_nxt;
    acc_r     <= acc_rdata;
    addr_d2_r <= addr_d1_r;
    if (cmd.out_load) begin
      out_entry_sum   <= rd_in_range ? acc_rdata : '0;
      out_frames_seen <= frames_r;
      out_overflowed  <= sat_seen_r;
    end
  end

  // Displacement from the stored reference
  assign dx = DISP_W'(cx_r) - DISP_W'($signed(ref_rdata[COORD_W-1:0]));
  assign dy = DISP_W'(cy_r) - DISP_W'($signed(ref_rdata[2*COORD_W-1:COORD_W]));
  assign dz = DISP_W'(cz_r) - DISP_W'($signed(ref_rdata[3*COORD_W-1:2*COORD_W]));
  assign disp_wdata = {dz, dy, dx};

  // Multiply stage, then saturating add stage
  assign dj       = pick(disp_rdata, jk_d_r);
  assign prod_nxt = PROD_W'(di_r) * PROD_W'(dj);
  assign sum      = (ACC_W+1)'(acc_r) + (ACC_W+1)'(prod_r);
  assign ovf      = sum[ACC_W] != sum[ACC_W-1];
  assign sat_val  = ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

  assign issue_addr  = acc_addr(lin_idx(cmd.ia, cmd.ik), lin_idx(cmd.ja, cmd.jk));
  assign rd_in_range = (row_r < SEL_W'(VEC_LEN)) && (col_r < SEL_W'(VEC_LEN));
  assign read_addr   = rd_in_range ? acc_addr(IDX_W'(row_r), IDX_W'(col_r)) : '0;
  assign acc_raddr   = cmd.acc_issue ? issue_addr : read_addr;
  assign acc_we      = cmd.clear_we || wr_v_r;
  assign acc_waddr   = cmd.clear_we ? cmd.clear_addr : addr_d2_r;
  assign acc_wdata   = cmd.clear_we ? '0 : sat_val;

  cpa_ram #(.WIDTH(REF_W), .DEPTH(MAX_ATOMS)) u_ref_ram (
    .clk   (clk),
    .we    (cmd.ref_we),
    .waddr (slot_r),
    .wdata ({cz_r, cy_r, cx_r}),
    .raddr (slot_r),
    .rdata (ref_rdata)
  );

  cpa_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ATOMS)) u_disp_ram (
    .clk   (clk),
    .we    (cmd.disp_we),
    .waddr (slot_r),
    .wdata (disp_wdata),
    .raddr (cmd.disp_ra),
    .rdata (disp_rdata)
  );

  cpa_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

endmodule

// ----- sv/covariance_outer_product_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// covariance_outer_product_accumulator_top
// Covariance accumulator: per-atom reference store, displacement store and a
// 3N x 3N saturating outer-product accumulator with frame tally.
// ----------------------------------------------------------------------------
// An item is transferred at a clock edge where start is high and busy is low.
// After reset the block clears all 36864 accumulator entries with busy high;
// configuration writes are taken at any time. Busy stays high while a load
// writes the reference row, a sample writes its displacement row or a read
// fetches its entry; a read result is shown in the cycle busy drops. A sample
// that ends a frame then walks the outer product: the sequencer issues one
// multiply-accumulate per cycle through the single accumulator memory port,
// pausing at the start of each row to fetch the row element, and then drains
// the two pipeline stages. Each result is shown for exactly one cycle with
// out_valid high; the receiver cannot stall it, so capture it on that cycle.
// ----------------------------------------------------------------------------
module covariance_outer_product_accumulator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Item channel
  input  logic                               start,
  output logic                               busy,
  input  logic [cpa_pkg::FUNC_W-1:0]         in_func,
  input  logic [cpa_pkg::SLOT_W-1:0]         in_atom_slot,
  input  logic signed [cpa_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [cpa_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [cpa_pkg::COORD_W-1:0] in_coord_z,
  input  logic                               in_frame_end,
  input  logic [cpa_pkg::SEL_W-1:0]          in_row_sel,
  input  logic [cpa_pkg::SEL_W-1:0]          in_col_sel,
  // Result channel
  output logic                               out_valid,
  output logic signed [cpa_pkg::ACC_W-1:0]   out_entry_sum,
  output logic [cpa_pkg::TALLY_W-1:0]        out_frames_seen,
  output logic                               out_overflowed,
  // Atom count register
  input  logic                               cfg_we,
  input  logic [cpa_pkg::CNT_W-1:0]          cfg_wdata
);
  import cpa_pkg::*;

  cpa_cmd_t  cmd;
  cpa_stat_t stat;

  // Sequencer: dispatch items, walk the outer product, run the clearing pass
  cpa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_func      (in_func),
    .in_frame_end (in_frame_end),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Memories, multiply-accumulate pipeline and result registers
  cpa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_atom_slot    (in_atom_slot),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .in_row_sel      (in_row_sel),
    .in_col_sel      (in_col_sel),
    .out_valid       (out_valid),
    .out_entry_sum   (out_entry_sum),
    .out_frames_seen (out_frames_seen),
    .out_overflowed  (out_overflowed)
  );

  // One read gives one single-cycle result
  a_out_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Reset starts the clearing pass, which blocks items
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block not busy after reset");

  // Clearing writes and accumulate issues never share the memory port
  a_port_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clear_we && (cmd.acc_issue || stat.pipe_busy)))
    else $error("clearing pass overlaps accumulation");

  // The frame is counted only once the pipeline has drained
  a_count_drained : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_done |-> !stat.pipe_busy && !cmd.acc_issue)
    else $error("frame counted with work in flight");

endmodule
